// ----- hdl/wfc_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and the delimiter test for the word frequency counter.
// Used by every module in hdl/; depends on nothing else.
package wfc_pkg;

    localparam int WORD_SLOTS_DEF = 512;
    localparam int WORD_CHARS_DEF = 11;
    localparam int COUNT_BITS_DEF = 16;

    // fixed widths of the result fields on the port
    localparam int SLOT_FIELD_W = 9;
    localparam int OCC_FIELD_W  = 16;
    localparam int M_TDATA_W    = 32;
    localparam int M_TUSER_W    = 3;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_PERIOD = 8'h2E;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_EXCL   = 8'h21;
    localparam logic [7:0] CH_QUEST  = 8'h3F;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;

    // status that travels with a finished word along the cell row
    typedef struct packed {
        logic valid;
        logic resolved;
        logic is_new;
        logic truncated;
    } wfc_flags_t;

    function automatic logic is_delim(input logic [7:0] c);
        return c inside {CH_NUL, CH_SPACE, CH_NL, CH_QUOTE, CH_PERIOD, CH_COMMA,
                         CH_SEMI, CH_COLON, CH_EXCL, CH_QUEST, CH_LPAREN, CH_RPAREN};
    endfunction

endpackage

// ----- hdl/wfc_word_builder.sv -----
`timescale 1ns / 1ps
// Collects text bytes into the pending word and launches a finished word
// into the cell row. Depends on wfc_pkg.
module wfc_word_builder
    import wfc_pkg::*;
#(
    parameter int WORD_CHARS = WORD_CHARS_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    advance,
    input  logic                    in_valid,
    input  logic [7:0]              text_byte,
    input  logic                    end_of_text,
    output wfc_flags_t              out_flags,
    output logic [WORD_CHARS*8-1:0] out_word
);

    localparam int LEN_W = $clog2(WORD_CHARS + 1);

    logic [WORD_CHARS*8-1:0] chars_reg, chars_next;
    logic [LEN_W-1:0]        len_reg, len_next;
    logic                    ovf_reg, ovf_next;
    wfc_flags_t              flags_reg, flags_next;
    logic [WORD_CHARS*8-1:0] word_reg, word_next;

    logic [WORD_CHARS*8-1:0] appended;
    logic                    delim;
    logic                    room;

    always_comb begin
        delim = is_delim(text_byte);
        room  = (len_reg < LEN_W'(WORD_CHARS));
        appended = chars_reg;
        for (int j = 0; j < WORD_CHARS; j++) begin
            if (room && (LEN_W'(j) == len_reg)) begin
                appended[j*8 +: 8] = text_byte;
            end
        end

        chars_next = chars_reg;
        len_next   = len_reg;
        ovf_next   = ovf_reg;
        flags_next = '0;
        word_next  = word_reg;

        if (advance && in_valid) begin
            if (delim) begin
                if (len_reg != '0) begin
                    flags_next.valid     = 1'b1;
                    flags_next.truncated = ovf_reg;
                    word_next            = chars_reg;
                    chars_next           = '0;
                    len_next             = '0;
                    ovf_next             = 1'b0;
                end
            end else if (end_of_text) begin
                // append first, then close the word
                flags_next.valid     = 1'b1;
                flags_next.truncated = ovf_reg | ~room;
                word_next            = appended;
                chars_next           = '0;
                len_next             = '0;
                ovf_next             = 1'b0;
            end else begin
                chars_next = appended;
                if (room) begin
                    len_next = len_reg + 1'b1;
                end else begin
                    ovf_next = 1'b1;
                end
            end
        end else if (!advance) begin
            flags_next = flags_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chars_reg <= '0;
            len_reg   <= '0;
            ovf_reg   <= 1'b0;
            flags_reg <= '0;
        end else begin
            chars_reg <= chars_next;
            len_reg   <= len_next;
            ovf_reg   <= ovf_next;
            flags_reg <= flags_next;
        end
    end

    always_ff @(posedge aclk) begin
        word_reg <= word_next;
    end

    assign out_flags = flags_reg;
    assign out_word  = word_reg;

endmodule

// ----- hdl/wfc_cell.sv -----
`timescale 1ns / 1ps
// One table slot: holds a word and its count, matches or claims a passing
// word and hands the word on to the next slot. Depends on wfc_pkg.
module wfc_cell
    import wfc_pkg::*;
#(
    parameter int WORD_CHARS = WORD_CHARS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF,
    parameter int SLOT_W     = 9,
    parameter int CELL_IDX   = 0
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    advance,
    input  wfc_flags_t              in_flags,
    input  logic [SLOT_W-1:0]       in_slot,
    input  logic [COUNT_BITS-1:0]   in_count,
    input  logic [WORD_CHARS*8-1:0] in_word,
    output wfc_flags_t              out_flags,
    output logic [SLOT_W-1:0]       out_slot,
    output logic [COUNT_BITS-1:0]   out_count,
    output logic [WORD_CHARS*8-1:0] out_word,
    output logic                    used
);

    logic                    used_reg, used_next;
    logic [WORD_CHARS*8-1:0] stored_reg, stored_next;
    logic [COUNT_BITS-1:0]   cnt_reg, cnt_next;
    wfc_flags_t              flags_reg, flags_next;
    logic [SLOT_W-1:0]       slot_reg, slot_next;
    logic [COUNT_BITS-1:0]   ocnt_reg, ocnt_next;
    logic [WORD_CHARS*8-1:0] word_reg, word_next;

    logic hit;
    logic claim;
    logic [COUNT_BITS-1:0] cnt_inc;

    always_comb begin
        hit     = used_reg && (stored_reg == in_word);
        claim   = !used_reg;
        cnt_inc = (cnt_reg == {COUNT_BITS{1'b1}}) ? cnt_reg : cnt_reg + 1'b1;

        used_next   = used_reg;
        stored_next = stored_reg;
        cnt_next    = cnt_reg;
        flags_next  = flags_reg;
        slot_next   = slot_reg;
        ocnt_next   = ocnt_reg;
        word_next   = word_reg;

        if (advance) begin
            flags_next = in_flags;
            slot_next  = in_slot;
            ocnt_next  = in_count;
            word_next  = in_word;
            if (in_flags.valid && !in_flags.resolved) begin
                if (hit) begin
                    cnt_next            = cnt_inc;
                    flags_next.resolved = 1'b1;
                    slot_next           = SLOT_W'(CELL_IDX);
                    ocnt_next           = cnt_inc;
                end else if (claim) begin
                    used_next           = 1'b1;
                    stored_next         = in_word;
                    cnt_next            = COUNT_BITS'(1);
                    flags_next.resolved = 1'b1;
                    flags_next.is_new   = 1'b1;
                    slot_next           = SLOT_W'(CELL_IDX);
                    ocnt_next           = COUNT_BITS'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg  <= 1'b0;
            flags_reg <= '0;
        end else begin
            used_reg  <= used_next;
            flags_reg <= flags_next;
        end
    end

    always_ff @(posedge aclk) begin
        stored_reg <= stored_next;
        cnt_reg    <= cnt_next;
        slot_reg   <= slot_next;
        ocnt_reg   <= ocnt_next;
        word_reg   <= word_next;
    end

    assign out_flags = flags_reg;
    assign out_slot  = slot_reg;
    assign out_count = ocnt_reg;
    assign out_word  = word_reg;
    assign used      = used_reg;

endmodule

// ----- hdl/word_frequency_counter.sv -----
`timescale 1ns / 1ps
// Word frequency counter: splits a byte stream into words and counts each
// distinct word in a row of table cells. Depends on wfc_pkg, wfc_word_builder, wfc_cell.
//
// Input channel s_: one text byte per transfer, s_tlast marks the final byte
// of the text and closes any word in progress. Delimiters (space, newline,
// quote, period, comma, semicolon, colon, exclamation, question mark,
// parentheses, NUL) close a word without producing a character.
// Result channel m_: one transfer per finished word with the slot, the
// saturating count and the new-word, table-full and truncated flags.
// A byte is taken every cycle while s_tready is high. A finished word walks
// the row of WORD_SLOTS cells, one cell per cycle while the row advances,
// and leaves through the output register; several words are in flight
// at once and results leave in input order.
// When m_tready is low with a result waiting, the whole row freezes and
// s_tready drops until the result is taken.
// Reset empties the table and discards any partial word; no clearing pass.
module word_frequency_counter
    import wfc_pkg::*;
#(
    parameter int WORD_SLOTS = WORD_SLOTS_DEF,
    parameter int WORD_CHARS = WORD_CHARS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,   // [7:0] text_byte
    input  logic                 s_tlast,   // end_of_text
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // [8:0] slot_index, [24:9] occurrences
    output logic [M_TUSER_W-1:0] m_tuser    // [0] is_new_word, [1] table_full_drop,
                                            // [2] word_truncated
);

    localparam int SLOT_W = $clog2(WORD_SLOTS);
    localparam int WORD_W = WORD_CHARS * 8;

    logic advance;

    wfc_flags_t            st_flags [0:WORD_SLOTS];
    logic [SLOT_W-1:0]     st_slot  [0:WORD_SLOTS];
    logic [COUNT_BITS-1:0] st_count [0:WORD_SLOTS];
    logic [WORD_W-1:0]     st_word  [0:WORD_SLOTS];
    logic [WORD_SLOTS-1:0] used_vec;

    logic                 m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic [M_TUSER_W-1:0] m_tuser_reg, m_tuser_next;

    logic [SLOT_FIELD_W+SLOT_W-1:0]    slot_wide;
    logic [OCC_FIELD_W+COUNT_BITS-1:0] occ_wide;
    wfc_flags_t                        tail;

    assign advance  = !m_tvalid_reg || m_tready;
    assign s_tready = advance;

    wfc_word_builder #(
        .WORD_CHARS (WORD_CHARS)
    ) u_builder (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .advance     (advance),
        .in_valid    (s_tvalid),
        .text_byte   (s_tdata),
        .end_of_text (s_tlast),
        .out_flags   (st_flags[0]),
        .out_word    (st_word[0])
    );

    assign st_slot[0]  = '0;
    assign st_count[0] = '0;

    for (genvar i = 0; i < WORD_SLOTS; i++) begin : g_cell
        wfc_cell #(
            .WORD_CHARS (WORD_CHARS),
            .COUNT_BITS (COUNT_BITS),
            .SLOT_W     (SLOT_W),
            .CELL_IDX   (i)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .advance   (advance),
            .in_flags  (st_flags[i]),
            .in_slot   (st_slot[i]),
            .in_count  (st_count[i]),
            .in_word   (st_word[i]),
            .out_flags (st_flags[i+1]),
            .out_slot  (st_slot[i+1]),
            .out_count (st_count[i+1]),
            .out_word  (st_word[i+1]),
            .used      (used_vec[i])
        );
    end

    always_comb begin
        tail      = st_flags[WORD_SLOTS];
        slot_wide = {{SLOT_FIELD_W{1'b0}}, st_slot[WORD_SLOTS]};
        occ_wide  = {{OCC_FIELD_W{1'b0}}, st_count[WORD_SLOTS]};

        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        if (advance) begin
            m_tvalid_next = tail.valid;
            m_tdata_next  = '0;
            m_tuser_next  = '0;
            // a word that no cell matched or claimed finds the table full
            if (tail.resolved) begin
                m_tdata_next[SLOT_FIELD_W-1:0] = slot_wide[SLOT_FIELD_W-1:0];
                m_tdata_next[SLOT_FIELD_W +: OCC_FIELD_W] = occ_wide[OCC_FIELD_W-1:0];
                m_tuser_next[0] = tail.is_new;
            end else begin
                m_tuser_next[1] = 1'b1;
            end
            m_tuser_next[2] = tail.truncated;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // occupied slots always form a prefix of the row
    a_used_prefix: assert property (@(posedge aclk) disable iff (!aresetn)
        (used_vec & (used_vec + 1'b1)) == '0)
        else $error("table slots not filled in order");

    a_new_count_one: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata[SLOT_FIELD_W +: OCC_FIELD_W] == OCC_FIELD_W'(1))
        else $error("new word without count of one");

    a_drop_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> !m_tuser[0] && m_tdata == '0)
        else $error("dropped word carries slot or count");

    a_drop_only_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> &used_vec)
        else $error("word dropped while table has room");

endmodule
